// File: rtl/bpam_pkg.sv
// Package for the border pad address mapper: register indexes, pad modes
// and fixed field widths. No dependencies.
package bpam_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_PAD_LEFT      = 3'd2,
        REG_PAD_RIGHT     = 3'd3,
        REG_PAD_TOP       = 3'd4,
        REG_PAD_BOTTOM    = 3'd5,
        REG_CHANNEL_COUNT = 3'd6,
        REG_PAD_MODE      = 3'd7
    } cfg_index_t;

    // border fill modes; the fourth code behaves as zero fill
    localparam logic [1:0] MODE_ZERO      = 2'd0;
    localparam logic [1:0] MODE_REPLICATE = 2'd1;
    localparam logic [1:0] MODE_REFLECT   = 2'd2;

    localparam int CFG_DIM_W   = 13;
    localparam int CFG_PAD_W   = 12;
    localparam int CFG_CH_W    = 3;
    localparam int CFG_MODE_W  = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int COORD_W     = 14;
    localparam int SRC_COORD_W = 12;
    localparam int SRC_ADDR_W  = 26;
    localparam int DST_ADDR_W  = 30;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 80;
    localparam int M_TUSER_W   = 3;

endpackage

// File: rtl/border_pad_address_mapper.sv
// Border pad address mapper, top level.
// Uses bpam_pkg for register indexes, mode codes and field widths.
//
// Usage:
//   Each item on the s_ channel is one pixel coordinate of the bordered
//   image. Each item on the m_ channel is the matching result: source
//   pixel, source and destination element addresses and three flags.
//   One result per item, in order.
//   Configuration (size, pads, channel count, fill mode) is written through
//   cfg_we / cfg_index / cfg_data while no item is in flight.
// Pipeline: four register stages, the first loaded at the accept edge: bounds,
//   axis mapping + row product, address sums, channel scaling and output register.
// Throughput: one item per cycle while the output is not stalled; every stage
//   takes a new item each cycle unless the stage after it is full and stalled.
// Stall: each stage holds while the one after it is full and stalled, so
//   bubbles collapse and s_tready drops only once all four stages are full.
// Reset: synchronous, active low; clears all stage valids and loads the
//   register reset values (1x1 image, no pads, 3 channels, zero fill).
module border_pad_address_mapper #(
    parameter int MAX_DIM      = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [bpam_pkg::CFG_DATA_W-1:0]   cfg_data,
    // coordinate items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [13:0] out_col, [27:14] out_row, [31:28] zero
    input  logic [bpam_pkg::S_TDATA_W-1:0]    s_tdata,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] src_col, [23:12] src_row, [49:24] src_address, [79:50] dst_address
    output logic [bpam_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] is_interior, [1] is_zero_fill, [2] is_outside
    output logic [bpam_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SAT_W = (DIM_W > bpam_pkg::CFG_DIM_W) ? DIM_W : bpam_pkg::CFG_DIM_W;
    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CHC_W = (CH_W > bpam_pkg::CFG_CH_W) ? CH_W : bpam_pkg::CFG_CH_W;
    localparam int NW_W  = SAT_W + 2;      // width + two pads
    localparam int D_W   = NW_W + 1;       // signed edge offset
    localparam int CW    = bpam_pkg::COORD_W;
    localparam int SW    = bpam_pkg::SRC_ADDR_W;
    localparam int DW    = bpam_pkg::DST_ADDR_W;

    // ---------------- configuration registers ----------------
    logic [bpam_pkg::CFG_DIM_W-1:0]  width_reg, height_reg;
    logic [bpam_pkg::CFG_PAD_W-1:0]  pad_l_reg, pad_r_reg, pad_t_reg, pad_b_reg;
    logic [bpam_pkg::CFG_CH_W-1:0]   chan_reg;
    logic [bpam_pkg::CFG_MODE_W-1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bpam_pkg::CFG_DIM_W'(1);
            height_reg <= bpam_pkg::CFG_DIM_W'(1);
            pad_l_reg  <= '0;
            pad_r_reg  <= '0;
            pad_t_reg  <= '0;
            pad_b_reg  <= '0;
            chan_reg   <= bpam_pkg::CFG_CH_W'(3);
            mode_reg   <= bpam_pkg::MODE_ZERO;
        end else if (cfg_we) begin
            case (bpam_pkg::cfg_index_t'(cfg_index))
                bpam_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                bpam_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                bpam_pkg::REG_PAD_LEFT:      pad_l_reg  <= cfg_data[bpam_pkg::CFG_PAD_W-1:0];
                bpam_pkg::REG_PAD_RIGHT:     pad_r_reg  <= cfg_data[bpam_pkg::CFG_PAD_W-1:0];
                bpam_pkg::REG_PAD_TOP:       pad_t_reg  <= cfg_data[bpam_pkg::CFG_PAD_W-1:0];
                bpam_pkg::REG_PAD_BOTTOM:    pad_b_reg  <= cfg_data[bpam_pkg::CFG_PAD_W-1:0];
                bpam_pkg::REG_CHANNEL_COUNT: chan_reg   <= cfg_data[bpam_pkg::CFG_CH_W-1:0];
                bpam_pkg::REG_PAD_MODE:      mode_reg   <= cfg_data[bpam_pkg::CFG_MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- clamped configuration ----------------
    // zero counts as one, anything above the maximum as the maximum
    logic [SAT_W-1:0] width_ext, height_ext;
    logic [CHC_W-1:0] chan_ext;
    logic [DIM_W-1:0] img_w, img_h;
    logic [CH_W-1:0]  chans;
    logic [NW_W-1:0]  frame_w, frame_h;

    always_comb begin
        width_ext  = SAT_W'(width_reg);
        height_ext = SAT_W'(height_reg);
        chan_ext   = CHC_W'(chan_reg);
        if (width_ext == '0)                     img_w = DIM_W'(1);
        else if (width_ext > SAT_W'(MAX_DIM))    img_w = DIM_W'(MAX_DIM);
        else                                     img_w = DIM_W'(width_ext);
        if (height_ext == '0)                    img_h = DIM_W'(1);
        else if (height_ext > SAT_W'(MAX_DIM))   img_h = DIM_W'(MAX_DIM);
        else                                     img_h = DIM_W'(height_ext);
        if (chan_ext == '0)                      chans = CH_W'(1);
        else if (chan_ext > CHC_W'(MAX_CHANNELS)) chans = CH_W'(MAX_CHANNELS);
        else                                     chans = CH_W'(chan_ext);
        frame_w = NW_W'(img_w) + NW_W'(pad_l_reg) + NW_W'(pad_r_reg);
        frame_h = NW_W'(img_h) + NW_W'(pad_t_reg) + NW_W'(pad_b_reg);
    end

    // map an offset from the image edge onto [0, n-1]
    function automatic logic [DIM_W-1:0] map_axis(
        input logic signed [D_W-1:0] d,
        input logic signed [D_W-1:0] n,
        input logic                  refl
    );
        logic signed [D_W:0] r;
        logic signed [D_W:0] dx;
        logic signed [D_W:0] nx;
        logic [DIM_W-1:0]    res;
        begin
            dx  = {d[D_W-1], d};
            nx  = {n[D_W-1], n};
            r   = '0;
            res = '0;
            if (d >= 0 && d < n) begin
                res = DIM_W'(d);
            end else if (refl) begin
                // mirror with the edge pixel repeated; ~d is -d-1
                if (d < 0) r = ~dx;
                else       r = (nx <<< 1) - dx - (D_W+1)'(1);
                if (r >= 0 && r < nx) res = DIM_W'(r);
                else                  res = '0;
            end else begin
                res = (d < 0) ? '0 : DIM_W'(n - 1);
            end
            map_axis = res;
        end
    endfunction

    // ---------------- handshake chain ----------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !s4_v_reg || m_tready;
    assign rdy3     = !s3_v_reg || rdy4;
    assign rdy2     = !s2_v_reg || rdy3;
    assign rdy1     = !s1_v_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end else begin
            if (rdy1) s1_v_reg <= s_tvalid;
            if (rdy2) s2_v_reg <= s1_v_reg;
            if (rdy3) s3_v_reg <= s2_v_reg;
            if (rdy4) s4_v_reg <= s3_v_reg;
        end
    end

    // ---------------- stage 1: frame bounds, edge offsets ----------------
    logic [CW-1:0]         s1_x_reg, s1_y_reg, s1_x_next, s1_y_next;
    logic signed [D_W-1:0] s1_dx_reg, s1_dy_reg, s1_dx_next, s1_dy_next;
    logic                  s1_out_reg, s1_out_next;

    always_comb begin
        s1_x_next   = s_tdata[CW-1:0];
        s1_y_next   = s_tdata[2*CW-1:CW];
        s1_out_next = (NW_W'(s1_x_next) >= frame_w) || (NW_W'(s1_y_next) >= frame_h);
        s1_dx_next  = $signed(D_W'(s1_x_next)) - $signed(D_W'(pad_l_reg));
        s1_dy_next  = $signed(D_W'(s1_y_next)) - $signed(D_W'(pad_t_reg));
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_x_reg   <= s1_x_next;
            s1_y_reg   <= s1_y_next;
            s1_dx_reg  <= s1_dx_next;
            s1_dy_reg  <= s1_dy_next;
            s1_out_reg <= s1_out_next;
        end
    end

    // ---------------- stage 2: axis mapping, row product ----------------
    logic [DIM_W-1:0] s2_sx_reg, s2_sy_reg, s2_sx_next, s2_sy_next;
    logic [DW-1:0]    s2_rowp_reg, s2_rowp_next;
    logic [CW-1:0]    s2_x_reg;
    logic             s2_int_reg, s2_int_next, s2_zero_reg, s2_zero_next, s2_out_reg;
    logic signed [D_W-1:0] wn, hn;
    logic             refl;

    always_comb begin
        wn   = $signed(D_W'(img_w));
        hn   = $signed(D_W'(img_h));
        refl = (mode_reg == bpam_pkg::MODE_REFLECT);
        s2_int_next  = (s1_dx_reg >= 0) && (s1_dx_reg < wn) &&
                       (s1_dy_reg >= 0) && (s1_dy_reg < hn);
        s2_zero_next = !s2_int_next && (mode_reg != bpam_pkg::MODE_REPLICATE) && !refl;
        if (s2_zero_next) begin
            s2_sx_next = '0;
            s2_sy_next = '0;
        end else begin
            s2_sx_next = map_axis(s1_dx_reg, wn, refl);
            s2_sy_next = map_axis(s1_dy_reg, hn, refl);
        end
        s2_rowp_next = DW'(s1_y_reg) * DW'(frame_w);
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_sx_reg   <= s2_sx_next;
            s2_sy_reg   <= s2_sy_next;
            s2_rowp_reg <= s2_rowp_next;
            s2_x_reg    <= s1_x_reg;
            s2_int_reg  <= s2_int_next;
            s2_zero_reg <= s2_zero_next;
            s2_out_reg  <= s1_out_reg;
        end
    end

    // ---------------- stage 3: pixel indexes ----------------
    logic [DIM_W-1:0] s3_sx_reg, s3_sy_reg;
    logic [SW-1:0]    s3_spix_reg, s3_spix_next;
    logic [DW-1:0]    s3_dpix_reg, s3_dpix_next;
    logic             s3_int_reg, s3_zero_reg, s3_out_reg;

    always_comb begin
        s3_spix_next = SW'(s2_sy_reg) * SW'(img_w) + SW'(s2_sx_reg);
        s3_dpix_next = s2_rowp_reg + DW'(s2_x_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_sx_reg   <= s2_sx_reg;
            s3_sy_reg   <= s2_sy_reg;
            s3_spix_reg <= s3_spix_next;
            s3_dpix_reg <= s3_dpix_next;
            s3_int_reg  <= s2_int_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_out_reg  <= s2_out_reg;
        end
    end

    // ---------------- stage 4: channel scaling, output register ----------------
    logic [bpam_pkg::M_TDATA_W-1:0] s4_data_reg, s4_data_next;
    logic [bpam_pkg::M_TUSER_W-1:0] s4_user_reg, s4_user_next;
    logic [SW-1:0]                  src_addr;
    logic [DW-1:0]                  dst_addr;

    always_comb begin
        src_addr = s3_spix_reg * SW'(chans);
        dst_addr = s3_dpix_reg * DW'(chans);
        if (s3_out_reg) begin
            // beyond the bordered frame: only the outside flag is set
            s4_data_next = '0;
            s4_user_next = 3'b100;
        end else begin
            s4_data_next = {dst_addr, src_addr,
                            s3_sy_reg[bpam_pkg::SRC_COORD_W-1:0],
                            s3_sx_reg[bpam_pkg::SRC_COORD_W-1:0]};
            s4_user_next = {1'b0, s3_zero_reg, s3_int_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            s4_data_reg <= s4_data_next;
            s4_user_reg <= s4_user_next;
        end
    end

    assign m_tvalid = s4_v_reg;
    assign m_tdata  = s4_data_reg;
    assign m_tuser  = s4_user_reg;

    // ---------------- assertions ----------------
    // outside results carry nothing but the flag
    a_outside_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tdata == '0 && m_tuser[1:0] == 2'b00))
        else $error("outside result carries data");

    // zero-filled pixels have no source
    a_zero_no_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[49:0] == '0))
        else $error("zero fill with nonzero source");

    // interior and zero fill exclude each other
    a_int_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("interior pixel marked zero fill");

    // a full stage blocked downstream keeps its item
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_v_reg && !rdy3) |=> (s2_v_reg && $stable(s2_rowp_reg) && $stable(s2_sx_reg)))
        else $error("stage two lost an item under stall");

    // stage three never advances while the output is stalled
    a_s3_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_v_reg && s4_v_reg && !m_tready) |=> (s3_v_reg && $stable(s3_dpix_reg)))
        else $error("stage three overwrote a waiting item");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for border_pad_address_mapper: maps coordinates under many geometries,
// predicts each result in place and compares field by field. Needs bpam_pkg and the block only.
module tb_top;

    localparam int DIM_LIMIT     = 4096;   // matches the block's default MAX_DIM
    localparam int CH_LIMIT      = 4;      // matches the block's default MAX_CHANNELS
    localparam int COORD_MAX     = (1 << bpam_pkg::COORD_W) - 1;
    localparam int SETTLE_CYCLES = 8;      // four pipeline stages plus margin
    localparam int LONG_HOLD     = 300;    // receiver hold-off used to back the pipe up
    localparam int RANDOM_SETS   = 12;
    localparam int ITEMS_PER_SET = 140;
    localparam logic [1:0] MODE_UNUSED = 2'd3;   // spare code, acts as zero fill

    // one coordinate item, col in the low bits as on s_tdata
    typedef struct packed {
        logic [bpam_pkg::COORD_W-1:0] row;
        logic [bpam_pkg::COORD_W-1:0] col;
    } coord_t;

    // one mapped result, fields in the order of the port description
    typedef struct packed {
        logic [bpam_pkg::SRC_COORD_W-1:0] src_col;
        logic [bpam_pkg::SRC_COORD_W-1:0] src_row;
        logic [bpam_pkg::SRC_ADDR_W-1:0]  src_addr;
        logic [bpam_pkg::DST_ADDR_W-1:0]  dst_addr;
        logic                             interior;
        logic                             zero_fill;
        logic                             outside;
    } pad_result_t;

    // ---------------------------------------------------------------
    // clock, reset and block ports; every input known from time zero
    // ---------------------------------------------------------------
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [2:0]                      cfg_index = '0;
    logic [bpam_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [bpam_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [bpam_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [bpam_pkg::M_TUSER_W-1:0]  m_tuser;

    always #5 aclk = ~aclk;

    border_pad_address_mapper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [13:0] out_col, [27:14] out_row, [31:28] zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [11:0] src_col, [23:12] src_row, [49:24] src_address,
                                 // [79:50] dst_address
        .m_tuser   (m_tuser)     // [0] is_interior, [1] is_zero_fill, [2] is_outside
    );

    // ---------------------------------------------------------------
    // bench copy of the geometry registers (reset values of the block)
    // ---------------------------------------------------------------
    logic [bpam_pkg::CFG_DIM_W-1:0]  geo_width  = 13'd1;
    logic [bpam_pkg::CFG_DIM_W-1:0]  geo_height = 13'd1;
    logic [bpam_pkg::CFG_PAD_W-1:0]  geo_left   = '0;
    logic [bpam_pkg::CFG_PAD_W-1:0]  geo_right  = '0;
    logic [bpam_pkg::CFG_PAD_W-1:0]  geo_top    = '0;
    logic [bpam_pkg::CFG_PAD_W-1:0]  geo_bottom = '0;
    logic [bpam_pkg::CFG_CH_W-1:0]   geo_chans  = 3'd3;
    logic [bpam_pkg::CFG_MODE_W-1:0] geo_mode   = bpam_pkg::MODE_ZERO;

    coord_t      coord_queue[$];     // coordinates waiting to be offered
    pad_result_t expected_maps[$];   // predictions for accepted coordinates, oldest first

    int  fail_count    = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  geometries    = 0;
    int  interior_hits = 0;
    int  zero_hits     = 0;
    int  outside_hits  = 0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    bit  send_idle     = 1'b1;
    bit  recv_idle     = 1'b1;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // fold an offset from the image edge back onto 0..n-1
    function automatic longint fold_axis(longint d, longint n, logic [1:0] mode);
        longint r;
        if (d >= 0 && d < n) return d;
        if (mode == bpam_pkg::MODE_REFLECT) begin
            r = (d < 0) ? -d - 1 : 2 * n - d - 1;
            // border wider than the image: mirror lands outside, use 0
            if (r < 0 || r >= n) r = 0;
            return r;
        end
        return (d < 0) ? 0 : n - 1;
    endfunction

    function automatic longint frame_cols();
        return clamp_to(longint'(geo_width), 1, DIM_LIMIT) + longint'(geo_left)
               + longint'(geo_right);
    endfunction

    function automatic longint frame_rows();
        return clamp_to(longint'(geo_height), 1, DIM_LIMIT) + longint'(geo_top)
               + longint'(geo_bottom);
    endfunction

    function automatic pad_result_t map_coord(logic [bpam_pkg::COORD_W-1:0] col,
                                              logic [bpam_pkg::COORD_W-1:0] row);
        pad_result_t r;
        longint      w, h, ch, x, y, nw, nh, dx, dy, sx, sy;
        logic [63:0] addr;
        r  = '0;
        w  = clamp_to(longint'(geo_width), 1, DIM_LIMIT);
        h  = clamp_to(longint'(geo_height), 1, DIM_LIMIT);
        ch = clamp_to(longint'(geo_chans), 1, CH_LIMIT);
        x  = longint'(col);
        y  = longint'(row);
        nw = frame_cols();
        nh = frame_rows();
        if (x >= nw || y >= nh) begin
            r.outside = 1'b1;
            return r;
        end
        addr       = (y * nw + x) * ch;
        r.dst_addr = addr[bpam_pkg::DST_ADDR_W-1:0];   // truncated to the field width
        dx = x - longint'(geo_left);
        dy = y - longint'(geo_top);
        r.interior  = dx >= 0 && dx < w && dy >= 0 && dy < h;
        r.zero_fill = !r.interior &&
                      (geo_mode == bpam_pkg::MODE_ZERO || geo_mode == MODE_UNUSED);
        if (!r.zero_fill) begin
            sx         = fold_axis(dx, w, geo_mode);
            sy         = fold_axis(dy, h, geo_mode);
            addr       = (sy * w + sx) * ch;
            r.src_col  = sx[bpam_pkg::SRC_COORD_W-1:0];
            r.src_row  = sy[bpam_pkg::SRC_COORD_W-1:0];
            r.src_addr = addr[bpam_pkg::SRC_ADDR_W-1:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // random shaping: mostly short gaps, now and then a long one
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly inside or just past the bordered frame, sometimes anywhere in the field
    function automatic coord_t random_coord();
        coord_t c;
        longint cols, rows;
        cols = frame_cols() + 1;
        rows = frame_rows() + 1;
        if ($urandom_range(0, 99) < 85) begin
            c.col = bpam_pkg::COORD_W'($urandom_range(0, int'(clamp_to(cols, 0, COORD_MAX))));
            c.row = bpam_pkg::COORD_W'($urandom_range(0, int'(clamp_to(rows, 0, COORD_MAX))));
        end else begin
            c.col = bpam_pkg::COORD_W'($urandom_range(0, COORD_MAX));
            c.row = bpam_pkg::COORD_W'($urandom_range(0, COORD_MAX));
        end
        return c;
    endfunction

    function automatic int random_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 12);
        if (r < 90) return 0;                                   // treated as 1
        if (r < 95) return $urandom_range(DIM_LIMIT, 8191);     // saturates
        return $urandom_range(1, DIM_LIMIT);
    endfunction

    function automatic int random_pad();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 6);
        if (r < 90) return $urandom_range(7, 64);
        return $urandom_range(0, 4095);
    endfunction

    // ---------------------------------------------------------------
    // configuration writes; only called while nothing is in flight
    // ---------------------------------------------------------------
    task automatic write_reg(bpam_pkg::cfg_index_t idx,
                             logic [bpam_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            bpam_pkg::REG_IMAGE_WIDTH:   geo_width  = value[bpam_pkg::CFG_DIM_W-1:0];
            bpam_pkg::REG_IMAGE_HEIGHT:  geo_height = value[bpam_pkg::CFG_DIM_W-1:0];
            bpam_pkg::REG_PAD_LEFT:      geo_left   = value[bpam_pkg::CFG_PAD_W-1:0];
            bpam_pkg::REG_PAD_RIGHT:     geo_right  = value[bpam_pkg::CFG_PAD_W-1:0];
            bpam_pkg::REG_PAD_TOP:       geo_top    = value[bpam_pkg::CFG_PAD_W-1:0];
            bpam_pkg::REG_PAD_BOTTOM:    geo_bottom = value[bpam_pkg::CFG_PAD_W-1:0];
            bpam_pkg::REG_CHANNEL_COUNT: geo_chans  = value[bpam_pkg::CFG_CH_W-1:0];
            bpam_pkg::REG_PAD_MODE:      geo_mode   = value[bpam_pkg::CFG_MODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(int w, int h, int pl, int pr, int pt, int pb,
                                int ch, logic [1:0] mode);
        write_reg(bpam_pkg::REG_IMAGE_WIDTH, bpam_pkg::CFG_DATA_W'(w));
        write_reg(bpam_pkg::REG_IMAGE_HEIGHT, bpam_pkg::CFG_DATA_W'(h));
        write_reg(bpam_pkg::REG_PAD_LEFT, bpam_pkg::CFG_DATA_W'(pl));
        write_reg(bpam_pkg::REG_PAD_RIGHT, bpam_pkg::CFG_DATA_W'(pr));
        write_reg(bpam_pkg::REG_PAD_TOP, bpam_pkg::CFG_DATA_W'(pt));
        write_reg(bpam_pkg::REG_PAD_BOTTOM, bpam_pkg::CFG_DATA_W'(pb));
        write_reg(bpam_pkg::REG_CHANNEL_COUNT, bpam_pkg::CFG_DATA_W'(ch));
        write_reg(bpam_pkg::REG_PAD_MODE, bpam_pkg::CFG_DATA_W'(mode));
        @(posedge aclk);
        cfg_we <= 1'b0;
        geometries++;
    endtask

    task automatic offer(int col, int row);
        coord_t c;
        c.col = bpam_pkg::COORD_W'(col);
        c.row = bpam_pkg::COORD_W'(row);
        coord_queue.push_back(c);
    endtask

    // wait until every queued coordinate has been mapped and checked;
    // sampled away from the rising edge so the clocked processes have settled
    task automatic drain();
        while (coord_queue.size() != 0 || s_tvalid || expected_maps.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(string tag, logic [63:0] want, logic [63:0] got);
        if (want != got) begin
            $display("%0t MISMATCH %s: expected %0d, actual %0d", $time, tag, want, got);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // driver: offers queued coordinates, predicts on each accept
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        logic offering;
        offering = s_tvalid;
        if (!aresetn) begin
            offering = 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_maps.push_back(map_coord(s_tdata[bpam_pkg::COORD_W-1:0],
                                                  s_tdata[2*bpam_pkg::COORD_W-1:bpam_pkg::COORD_W]));
                items_sent++;
                offering = 1'b0;
            end
            // next coordinate goes out once the random gap has run down
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (coord_queue.size() > 0) begin
                    s_tdata  <= bpam_pkg::S_TDATA_W'(coord_queue.pop_front());
                    offering = 1'b1;
                    send_gap = send_idle ? pick_gap() : 0;
                end
            end
        end
        s_tvalid <= offering;   // single update per edge
    end

    // ---------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                stall_left  = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_idle && $urandom_range(0, 99) < 20) stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: every accepted result against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        pad_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.src_col   = m_tdata[11:0];
            got.src_row   = m_tdata[23:12];
            got.src_addr  = m_tdata[49:24];
            got.dst_addr  = m_tdata[79:50];
            got.interior  = m_tuser[0];
            got.zero_fill = m_tuser[1];
            got.outside   = m_tuser[2];
            results_seen++;
            if (expected_maps.size() == 0) begin
                $display("%0t MISMATCH unexpected result: expected none, actual %h/%h",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = expected_maps.pop_front();
                check_field("src_col", 64'(want.src_col), 64'(got.src_col));
                check_field("src_row", 64'(want.src_row), 64'(got.src_row));
                check_field("src_address", 64'(want.src_addr), 64'(got.src_addr));
                check_field("dst_address", 64'(want.dst_addr), 64'(got.dst_addr));
                check_field("is_interior", 64'(want.interior), 64'(got.interior));
                check_field("is_zero_fill", 64'(want.zero_fill), 64'(got.zero_fill));
                check_field("is_outside", 64'(want.outside), 64'(got.outside));
                interior_hits += int'(want.interior);
                zero_hits     += int'(want.zero_fill);
                outside_hits  += int'(want.outside);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry: 1x1 image, no border, zero fill
        offer(0, 0);
        offer(1, 0);
        offer(0, 1);
        offer(COORD_MAX, COORD_MAX);
        drain();

        // small reflect case, corners and interior
        set_geometry(4, 3, 2, 2, 2, 2, 3, bpam_pkg::MODE_REFLECT);
        offer(0, 0);
        offer(7, 6);
        offer(2, 2);
        offer(5, 4);
        offer(1, 6);
        drain();

        // reflect with border wider than the image: mirrored index falls back to 0
        set_geometry(2, 1, 5, 5, 5, 5, 2, bpam_pkg::MODE_REFLECT);
        offer(0, 0);
        offer(11, 10);
        offer(6, 5);
        drain();

        // spare mode code, zero width and zero channels
        set_geometry(0, 2, 1, 1, 1, 1, 0, MODE_UNUSED);
        offer(0, 0);
        offer(1, 1);
        offer(2, 2);
        drain();

        // largest geometry: oversize dims saturate, 7 channels saturate
        set_geometry(8191, 5000, 4095, 4095, 4095, 4095, 7, bpam_pkg::MODE_REPLICATE);
        offer(0, 0);
        offer(12285, 12285);
        offer(12286, 5);
        offer(5, 12286);
        offer(COORD_MAX, COORD_MAX);
        offer(6000, 6000);
        drain();

        // replicate, uneven pads, four channels
        set_geometry(3, 2, 3, 0, 1, 2, 4, bpam_pkg::MODE_REPLICATE);
        offer(0, 0);
        offer(5, 4);
        offer(3, 1);
        drain();

        // random geometries; every mode in turn, some sets without idling
        for (int set_no = 0; set_no < RANDOM_SETS; set_no++) begin
            set_geometry(random_dim(), random_dim(), random_pad(), random_pad(),
                         random_pad(), random_pad(), $urandom_range(0, 7), 2'(set_no % 4));
            send_idle = (set_no % 3 != 2);
            recv_idle = (set_no % 3 != 2);
            if (set_no == 5) begin
                // back the pipe up: sender streams while the receiver holds off
                send_idle = 1'b0;
                hold_requests++;
            end
            for (int n = 0; n < ITEMS_PER_SET; n++) coord_queue.push_back(random_coord());
            drain();
        end

        $display("Mapped %0d coordinates over %0d geometries, %0d results checked.",
                 items_sent, geometries, results_seen);
        $display("Results: %0d interior, %0d zero fill, %0d beyond the frame.",
                 interior_hits, zero_hits, outside_hits);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #8000000;
        $display("Timeout with %0d predictions outstanding.", expected_maps.size());
        $display("simulation failed");
        $finish;
    end

endmodule
